### sv/dcds_pkg.sv
// ============================================================================
// dcds_pkg
// Shared types and constants for the dispatch scoreboard scheduler.
// ============================================================================
package dcds_pkg;

   localparam int NUM_IDS = 64;
   localparam int ID_W    = 6;
   localparam int CNT_W   = 7;
   localparam int FC_W    = 7;

   localparam logic [1:0] FUNC_ACQUIRE  = 2'd0;
   localparam logic [1:0] FUNC_ADD_DEP  = 2'd1;
   localparam logic [1:0] FUNC_SUBMIT   = 2'd2;
   localparam logic [1:0] FUNC_COMPLETE = 2'd3;

   localparam logic [1:0] ST_ACQUIRED = 2'd0;
   localparam logic [1:0] ST_NO_FREE  = 2'd1;
   localparam logic [1:0] ST_LAUNCHED = 2'd2;
   localparam logic [1:0] ST_ACCEPTED = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_UPD   = 5'b01000,
      S_FLUSH = 5'b10000
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec_go;
      logic scan_step;
      logic walk_rd;
      logic upd_go;
      logic flush_go;
   } cmd_type;

   typedef struct packed {
      logic is_complete;
      logic walk_bit;
      logic idx_last;
      logic out_free;
      logic upd_need_out;
   } stat_type;

endpackage

### sv/dcds_ram.sv
// ============================================================================
// dcds_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module dcds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/dcds_ctrl.sv
// ============================================================================
// dcds_ctrl
// Sequencer: accepts one request, then steps the datapath through it.
// ============================================================================
module dcds_ctrl import dcds_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            // complete needs no slot here: it only loads the walk
            if (stat.is_complete || stat.out_free) begin
               cmd.exec_go = 1'b1;
               state_in    = stat.is_complete ? S_SCAN : S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.walk_rd   = 1'b1;
            cmd.scan_step = 1'b1;
            if (stat.walk_bit) begin
               state_in = S_UPD;
            end else if (stat.idx_last) begin
               state_in = S_FLUSH;
            end
         end
         S_UPD: begin
            cmd.walk_rd = 1'b1;
            if (!stat.upd_need_out || stat.out_free) begin
               cmd.upd_go = 1'b1;
               state_in   = stat.idx_last ? S_FLUSH : S_SCAN;
            end
         end
         S_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush_go = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/dcds_datapath.sv
// ============================================================================
// dcds_datapath
// Free stack, waiter bitmaps, pending counts, walk register and result slot.
// ============================================================================
module dcds_datapath import dcds_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [1:0]        req_func,
   input  logic [ID_W-1:0]   req_target_id,
   input  logic [ID_W-1:0]   req_source_id,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_result_id,
   output logic              rsp_last
);

   localparam logic [FC_W-1:0]  FC_FULL = FC_W'(NUM_IDS);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NUM_IDS);

   // request registers
   logic [1:0]      func_ff;
   logic [ID_W-1:0] tgt_ff, src_ff;
   logic            empty_ff;
   logic [FC_W-1:0] free_count_ff, free_count_in;

   // valid bits: unwritten entries read as reset value
   logic [NUM_IDS-1:0] stk_vld_ff, bm_vld_ff, cnt_vld_ff;
   logic [ID_W-1:0]    stk_raddr_ff;
   logic               stk_rvld_ff, bm_rvld_ff, cnt_rvld_ff;

   logic               stk_we;
   logic [ID_W-1:0]    stk_waddr, stk_raddr, stk_rdata, stk_eff;
   logic               bm_we;
   logic [ID_W-1:0]    bm_waddr, bm_raddr;
   logic [NUM_IDS-1:0] bm_wdata, bm_rdata, bm_eff;
   logic               cnt_we;
   logic [ID_W-1:0]    cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]   cnt_wdata, cnt_rdata, cnt_eff;

   // walk state
   logic [NUM_IDS-1:0] walk_ff;
   logic [ID_W-1:0]    idx_ff;
   logic               held_v_ff;
   logic [ID_W-1:0]    held_id_ff;
   logic               launch;

   // result slot
   logic            out_v_ff, out_last_ff, load_out, out_free;
   logic [1:0]      out_st_ff, out_st_in;
   logic [ID_W-1:0] out_id_ff, out_id_in;
   logic            out_last_in;

   assign stk_eff = stk_rvld_ff ? stk_rdata : stk_raddr_ff;
   assign bm_eff  = bm_rvld_ff ? bm_rdata : '0;
   assign cnt_eff = cnt_rvld_ff ? cnt_rdata : '0;
   assign out_free = !out_v_ff || !rsp_stall;
   assign launch   = (cnt_eff == CNT_W'(1));

   always_comb begin
      // read addresses stay on the held request while the result slot is busy
      stk_raddr = cmd.accept ? ID_W'(free_count_ff - FC_W'(1)) : stk_raddr_ff;
      bm_raddr  = cmd.accept ?
                  ((req_func == FUNC_ADD_DEP) ? req_source_id : req_target_id) :
                  ((func_ff == FUNC_ADD_DEP) ? src_ff : tgt_ff);
      cnt_raddr = cmd.walk_rd ? idx_ff : (cmd.accept ? req_target_id : tgt_ff);

      stk_we    = cmd.accept && req_func == FUNC_COMPLETE && free_count_ff < FC_FULL;
      stk_waddr = free_count_ff[ID_W-1:0];

      free_count_in = free_count_ff;
      if (cmd.accept && req_func == FUNC_ACQUIRE && free_count_ff != '0) begin
         free_count_in = free_count_ff - FC_W'(1);
      end else if (stk_we) begin
         free_count_in = free_count_ff + FC_W'(1);
      end

      bm_we     = 1'b0;
      bm_waddr  = src_ff;
      bm_wdata  = bm_eff | (NUM_IDS'(1) << tgt_ff);
      cnt_we    = 1'b0;
      cnt_waddr = tgt_ff;
      cnt_wdata = cnt_eff + CNT_W'(1);

      load_out    = 1'b0;
      out_st_in   = ST_ACCEPTED;
      out_id_in   = '0;
      out_last_in = 1'b1;

      if (cmd.exec_go) begin
         case (func_ff)
            FUNC_ACQUIRE: begin
               load_out = 1'b1;
               if (empty_ff) begin
                  out_st_in = ST_NO_FREE;
               end else begin
                  out_st_in = ST_ACQUIRED;
                  out_id_in = stk_eff;
                  bm_we     = 1'b1;
                  bm_waddr  = stk_eff;
                  bm_wdata  = '0;
                  cnt_we    = 1'b1;
                  cnt_waddr = stk_eff;
                  cnt_wdata = '0;
               end
            end
            FUNC_ADD_DEP: begin
               load_out = 1'b1;
               if (!bm_eff[tgt_ff]) begin
                  bm_we  = 1'b1;
                  cnt_we = cnt_eff < CNT_MAX;
               end
            end
            FUNC_SUBMIT: begin
               load_out = 1'b1;
               if (cnt_eff == '0) begin
                  out_st_in = ST_LAUNCHED;
                  out_id_in = tgt_ff;
               end
            end
            default: ;
         endcase
      end

      if (cmd.upd_go) begin
         cnt_waddr = idx_ff;
         cnt_wdata = cnt_eff - CNT_W'(1);
         cnt_we    = (cnt_eff != '0);
         if (launch && held_v_ff) begin
            load_out    = 1'b1;
            out_st_in   = ST_LAUNCHED;
            out_id_in   = held_id_ff;
            out_last_in = 1'b0;
         end
      end

      if (cmd.flush_go) begin
         load_out  = 1'b1;
         out_st_in = held_v_ff ? ST_LAUNCHED : ST_ACCEPTED;
         out_id_in = held_v_ff ? held_id_ff : '0;
      end
   end

   dcds_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(req_target_id),
      .raddr(stk_raddr), .rdata(stk_rdata)
   );

   dcds_ram #(.WIDTH(NUM_IDS), .DEPTH(NUM_IDS)) u_bitmap (
      .clock(clock), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
      .raddr(bm_raddr), .rdata(bm_rdata)
   );

   dcds_ram #(.WIDTH(CNT_W), .DEPTH(NUM_IDS)) u_count (
      .clock(clock), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
      .raddr(cnt_raddr), .rdata(cnt_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= FC_FULL;
         stk_vld_ff    <= '0;
         bm_vld_ff     <= '0;
         cnt_vld_ff    <= '0;
         stk_rvld_ff   <= 1'b0;
         bm_rvld_ff    <= 1'b0;
         cnt_rvld_ff   <= 1'b0;
         held_v_ff     <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         if (stk_we) stk_vld_ff[stk_waddr] <= 1'b1;
         if (bm_we)  bm_vld_ff[bm_waddr]   <= 1'b1;
         if (cnt_we) cnt_vld_ff[cnt_waddr] <= 1'b1;
         stk_rvld_ff <= stk_vld_ff[stk_raddr];
         bm_rvld_ff  <= bm_vld_ff[bm_raddr];
         cnt_rvld_ff <= cnt_vld_ff[cnt_raddr];
         if (cmd.exec_go) begin
            held_v_ff <= 1'b0;
         end else if (cmd.upd_go && launch) begin
            held_v_ff <= 1'b1;
         end
         if (load_out) begin
            out_v_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      stk_raddr_ff <= stk_raddr;
      if (cmd.accept) begin
         func_ff  <= req_func;
         tgt_ff   <= req_target_id;
         src_ff   <= req_source_id;
         empty_ff <= (free_count_ff == '0);
      end
      if (cmd.exec_go) begin
         walk_ff <= bm_eff;
         idx_ff  <= '0;
      end else if ((cmd.scan_step && !walk_ff[idx_ff]) || cmd.upd_go) begin
         idx_ff <= idx_ff + ID_W'(1);
      end
      if (cmd.upd_go && launch) begin
         held_id_ff <= idx_ff;
      end
      if (load_out) begin
         out_st_ff   <= out_st_in;
         out_id_ff   <= out_id_in;
         out_last_ff <= out_last_in;
      end
   end

   assign stat.is_complete  = (func_ff == FUNC_COMPLETE);
   assign stat.walk_bit     = walk_ff[idx_ff];
   assign stat.idx_last     = (idx_ff == ID_W'(NUM_IDS - 1));
   assign stat.out_free     = out_free;
   assign stat.upd_need_out = launch && held_v_ff;

   assign rsp_valid     = out_v_ff;
   assign rsp_status    = out_st_ff;
   assign rsp_result_id = out_id_ff;
   assign rsp_last      = out_last_ff;

`ifndef SYNTH
   a_free_count_range: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= FC_FULL) else $error("free count beyond id range");
   a_slot_free_on_load: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free) else $error("result slot overwritten");
   a_flush_is_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_go |=> (out_v_ff && out_last_ff)) else $error("flush without last");
   a_no_zero_decrement: assert property (@(posedge clock) disable iff (reset)
      (cmd.upd_go && cnt_we) |-> (cnt_eff != '0)) else $error("count underflow");
`endif

endmodule

### sv/dependency_counting_dispatch_scheduler.sv
// ============================================================================
// dependency_counting_dispatch_scheduler
// Scoreboard of 64 dispatch ids with LIFO free stack and dependency counts.
// ============================================================================
// One request is handled at a time. Acquire, add dependency and submit pass
// through the transfer, which issues the RAM reads, then the result load,
// which waits for the result register to empty, before the next request
// transfers. Complete transfers, loads the walk from the waiter bitmap and
// scans it one id per cycle in ascending order; each set bit adds an update
// step for the read-modify-write of its pending count, which halts the scan
// and may wait on the result register, and a flush step ends the walk. Each
// launch is held back one step so that the final result of a walk can carry
// last; a walk with no launch ends in a single accepted-without-launch result.
// The result register lets a new request transfer while the previous result
// waits on rsp_stall. No clearing pass is needed after reset: per-entry valid
// bits supply the reset contents of the free stack, bitmaps and counts.
module dependency_counting_dispatch_scheduler import dcds_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_func,
   input  logic [ID_W-1:0] req_target_id,
   input  logic [ID_W-1:0] req_source_id,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [ID_W-1:0] rsp_result_id,
   output logic            rsp_last
);

   cmd_type  cmd;   // controller to datapath
   stat_type stat;  // datapath to controller

   // sequencer
   dcds_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .stat(stat), .cmd(cmd)
   );

   // storage, walk and result slot
   dcds_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_func(req_func), .req_target_id(req_target_id),
      .req_source_id(req_source_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_result_id(rsp_result_id),
      .rsp_last(rsp_last)
   );

endmodule
